// ===== design/base64_line_encoder_macros.svh =====
// Assertion macros shared by the encoder top level.
`ifndef BASE64_LINE_ENCODER_MACROS_SVH
`define BASE64_LINE_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define B64LE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define B64LE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/b64le_pkg.sv =====
package b64le_pkg;

  // Most results one item can cause
  localparam int NUM_RES = 3;
  localparam int RES_IDX_W = $clog2(NUM_RES);
  localparam int RES_CNT_W = $clog2(NUM_RES + 1);

  // Bundles held between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0] NEWLINE_CODE = 7'd10;
  localparam logic [6:0] PAD_CODE = 7'd61;
  localparam logic [7:0] LINE_LENGTH_RESET = 8'd76;

  typedef enum logic {
    OP_DATA   = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic [7:0] repeat_res;
    logic       last;
  } res_t;

  // All results of one item, in order, with their count
  typedef struct packed {
    logic [RES_CNT_W-1:0]   cnt;
    res_t [NUM_RES-1:0]     res;
  } bundle_t;

  // Base64 alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [6:0] b64_char(input logic [5:0] sym);
    logic [6:0] code;
    if (sym < 6'd26) begin
      code = 7'd65 + {1'b0, sym};
    end else if (sym < 6'd52) begin
      code = 7'd71 + {1'b0, sym};
    end else if (sym < 6'd62) begin
      code = {1'b0, sym} - 7'd4;
    end else if (sym == 6'd62) begin
      code = 7'd43;
    end else begin
      code = 7'd47;
    end
    return code;
  endfunction

endpackage

// ===== design/b64le_front.sv =====
module b64le_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic [7:0]           data_byte,
  output logic                 push_valid,
  input  logic                 push_ready,
  output b64le_pkg::bundle_t   push_bundle
);

  logic [7:0] line_length;
  logic [7:0] line_count;
  logic [3:0] leftover_bits;
  logic [2:0] leftover_count;

  logic [7:0] line_count_next;
  logic [3:0] leftover_bits_next;
  logic [2:0] leftover_count_next;
  b64le_pkg::bundle_t bundle_next;

  logic accept;

  // Work out all results of the item and the state it leaves
  always_comb begin
    logic [7:0]  lc;
    logic [1:0]  n;
    logic [1:0]  k;
    logic [5:0]  syms [2];
    logic [2:0]  remaining;
    logic        have_bits;
    logic [8:0]  eff_len;
    logic [8:0]  lcv;
    logic [11:0] shifted;
    logic [11:0] val;

    lc = line_count;
    n = '0;
    k = '0;
    syms[0] = '0;
    syms[1] = '0;
    remaining = '0;
    val = {leftover_bits, data_byte};
    have_bits = (leftover_count != 3'd0);
    eff_len = (line_length == 8'd0) ? 9'd256 : {1'b0, line_length};
    lcv = '0;
    shifted = '0;
    bundle_next = '0;
    leftover_bits_next = '0;
    leftover_count_next = '0;

    unique case (b64le_pkg::op_t'(op))
      b64le_pkg::OP_DATA: begin
        // Split the bits into 6-bit symbols, MSB first
        unique case (leftover_count)
          3'd2: begin
            k = 2'd1;
            syms[0] = {leftover_bits[1:0], data_byte[7:4]};
            leftover_bits_next = data_byte[3:0];
            leftover_count_next = 3'd4;
          end
          3'd4: begin
            k = 2'd2;
            syms[0] = val[11:6];
            syms[1] = val[5:0];
          end
          default: begin
            k = 2'd1;
            syms[0] = data_byte[7:2];
            leftover_bits_next = {2'b00, data_byte[1:0]};
            leftover_count_next = 3'd2;
          end
        endcase

        // Emit symbols with newline handling, at most three results
        for (int i = 0; i < 2; i++) begin
          if (2'(i) < k) begin
            remaining = {1'b0, k} - 3'(i);
            if (line_length != 8'd0 && lc == line_length) begin
              if ({1'b0, n} + remaining < 3'd3) begin
                bundle_next.res[n] = '{b64le_pkg::NEWLINE_CODE, 8'd1, 1'b0};
                n = n + 2'd1;
              end
              lc = '0;
            end
            bundle_next.res[n] = '{b64le_pkg::b64_char(syms[i]), 8'd1, 1'b0};
            n = n + 2'd1;
            lc = lc + 8'd1;
            if (lc == line_length && {1'b0, n} + remaining <= 3'd3) begin
              bundle_next.res[n] = '{b64le_pkg::NEWLINE_CODE, 8'd1, 1'b0};
              n = n + 2'd1;
              lc = '0;
            end
          end
        end
        line_count_next = lc;
      end
      default: begin
        // Finish: flush, pad the line, newline; state returns to reset
        line_count_next = '0;
        if (have_bits || lc != 8'd0) begin
          if (line_length != 8'd0 && lc == line_length && !have_bits) begin
            bundle_next.res[n] = '{b64le_pkg::NEWLINE_CODE, 8'd1, 1'b1};
            n = n + 2'd1;
          end else begin
            if (line_length != 8'd0 && lc == line_length) begin
              // Held newline goes out only if it still fits
              if (eff_len <= 9'd1) begin
                bundle_next.res[n] = '{b64le_pkg::NEWLINE_CODE, 8'd1, 1'b0};
                n = n + 2'd1;
              end
              lc = '0;
            end
            lcv = {1'b0, lc};
            if (have_bits) begin
              shifted = {leftover_bits, 8'd0} >> ({1'b0, leftover_count} + 4'd2);
              bundle_next.res[n] = '{b64le_pkg::b64_char(shifted[5:0]), 8'd1, 1'b0};
              n = n + 2'd1;
              lcv = lcv + 9'd1;
            end
            if (lcv < eff_len) begin
              bundle_next.res[n] = '{b64le_pkg::PAD_CODE, 8'(eff_len - lcv), 1'b0};
              n = n + 2'd1;
            end
            bundle_next.res[n] = '{b64le_pkg::NEWLINE_CODE, 8'd1, 1'b1};
            n = n + 2'd1;
          end
        end
      end
    endcase

    bundle_next.cnt = n;
  end

  assign in_ready = push_ready;
  assign accept = in_valid && in_ready;
  assign push_valid = accept && (bundle_next.cnt != '0);
  assign push_bundle = bundle_next;

  // Encoder state and line length register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= b64le_pkg::LINE_LENGTH_RESET;
      line_count <= '0;
      leftover_bits <= '0;
      leftover_count <= '0;
    end else begin
      if (cfg_we) begin
        line_length <= cfg_wdata;
      end
      if (accept) begin
        line_count <= line_count_next;
        leftover_bits <= leftover_bits_next;
        leftover_count <= leftover_count_next;
      end
    end
  end

endmodule

// ===== design/b64le_queue.sv =====
module b64le_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  b64le_pkg::bundle_t   push_bundle,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output b64le_pkg::bundle_t   pop_bundle
);

  b64le_pkg::bundle_t entries [b64le_pkg::QUEUE_DEPTH];
  logic [b64le_pkg::QPTR_W-1:0] wr_ptr;
  logic [b64le_pkg::QPTR_W-1:0] rd_ptr;
  logic [b64le_pkg::QCNT_W-1:0] level;
  logic do_push;
  logic do_pop;

  assign push_ready = (level != b64le_pkg::QCNT_W'(b64le_pkg::QUEUE_DEPTH));
  assign pop_valid = (level != '0);
  assign pop_bundle = entries[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_bundle;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == b64le_pkg::QPTR_W'(b64le_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == b64le_pkg::QPTR_W'(b64le_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

// ===== design/b64le_back.sv =====
module b64le_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  b64le_pkg::bundle_t   pop_bundle,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [6:0]           char_code,
  output logic [7:0]           repeat_res,
  output logic                 last
);

  logic [b64le_pkg::RES_IDX_W-1:0] idx;
  logic load;
  logic at_end;
  b64le_pkg::res_t cur;

  assign cur = pop_bundle.res[idx];
  assign load = pop_valid && (!out_valid || out_ready);
  assign at_end = (b64le_pkg::RES_CNT_W'(idx) ==
                   pop_bundle.cnt - b64le_pkg::RES_CNT_W'(1));
  assign pop_ready = load && at_end;

  // Walk through the head bundle, one result per cycle while out_ready is high
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx <= at_end ? '0 : idx + 1'b1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      char_code <= cur.char_code;
      repeat_res <= cur.repeat_res;
      last <= cur.last;
    end
  end

endmodule

// ===== design/base64_line_encoder.sv =====
// The first result of an accepted item goes through a queue entry, then the output register.
// Throughput: one result per cycle from the output register while out_ready holds;
// one item per cycle while each item yields one result and the queue is not full.
// Items causing up to three results are sent out one result at a time.
// Reset (rst, synchronous): line length 76, leftover bits and line count cleared.
`include "base64_line_encoder_macros.svh"

module base64_line_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] char_code,
  output logic [7:0] repeat_res,
  output logic       last
);

  logic push_valid;
  logic push_ready;
  b64le_pkg::bundle_t push_bundle;
  logic pop_valid;
  logic pop_ready;
  b64le_pkg::bundle_t pop_bundle;
  logic is_newline;
  logic is_pad;

  // Front: accept items, build result bundles
  b64le_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .data_byte   (data_byte),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_bundle (push_bundle)
  );

  // Short queue between front and back
  b64le_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_bundle (push_bundle),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_bundle  (pop_bundle)
  );

  // Back: send results out one at a time
  b64le_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_bundle (pop_bundle),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_code  (char_code),
    .repeat_res (repeat_res),
    .last       (last)
  );

  // Output character classes
  assign is_newline = (char_code == b64le_pkg::NEWLINE_CODE);
  assign is_pad = (char_code == b64le_pkg::PAD_CODE);

  // Checks
  `B64LE_ASSERT_NOW(a_push_nonempty, push_valid, push_bundle.cnt != '0, "empty bundle pushed")
  `B64LE_ASSERT_NOW(a_last_newline, out_valid && last, is_newline, "last not newline")
  `B64LE_ASSERT_NOW(a_run_is_pad, out_valid && repeat_res != 8'd1, is_pad, "run not pad")
  `B64LE_ASSERT_NEXT(a_full_has_head, !push_ready, pop_valid || push_ready, "queue state lost")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int CLK_HALF = 6;
  localparam int RST_CYCLES = 9;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 10;

  // Predicts the character stream and checks it against the block output
  class char_scoreboard;
    logic [7:0]      line_len;
    logic [3:0]      carry_bits;
    logic [2:0]      carry_cnt;
    logic [7:0]      col;
    b64le_pkg::res_t exp_chars[$];
    string           alphabet;
    int              errors;
    int              items;
    int              finishes;
    int              chars_seen;
    int              pad_runs;
    int              newlines;

    function new();
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      line_len = b64le_pkg::LINE_LENGTH_RESET;
      clear_state();
    endfunction

    function void clear_state();
      carry_bits = '0;
      carry_cnt = '0;
      col = '0;
    endfunction

    function void set_length(logic [7:0] v);
      line_len = v;
    endfunction

    function int pending();
      return exp_chars.size();
    endfunction

    // Newline owed from an earlier item (line already full)
    function bit nl_held();
      return line_len != 8'd0 && col == line_len;
    endfunction

    function logic [6:0] sym_code(logic [5:0] s);
      byte b;
      b = alphabet[int'(s)];
      return b[6:0];
    endfunction

    function void push(logic [6:0] c, logic [7:0] r, logic l);
      b64le_pkg::res_t x;
      x.char_code = c;
      x.repeat_res = r;
      x.last = l;
      exp_chars.insert(exp_chars.size(), x);
    endfunction

    // Works out the characters one accepted item produces
    function void encode_item(b64le_pkg::op_t o, logic [7:0] b);
      int          total;
      int          k;
      int          n;
      int          rem;
      int          e;
      int          lc;
      logic [11:0] val;
      logic [5:0]  syms [2];
      logic [5:0]  tail;
      items++;
      n = 0;
      if (o == b64le_pkg::OP_DATA) begin
        total = int'(carry_cnt) + 8;
        val = {carry_bits, b};
        k = 0;
        while (total >= 6 && k < 2) begin
          syms[k] = 6'(val >> (total - 6));
          total -= 6;
          k++;
        end
        carry_cnt = 3'(total);
        carry_bits = 4'(val & ((12'd1 << total) - 12'd1));
        for (int i = 0; i < k; i++) begin
          rem = k - i;
          // owed newline goes out first if there is room, else it is lost
          if (nl_held()) begin
            if (b64le_pkg::NUM_RES - n > rem) begin
              push(b64le_pkg::NEWLINE_CODE, 8'd1, 1'b0);
              n++;
            end
            col = '0;
          end
          push(sym_code(syms[i]), 8'd1, 1'b0);
          n++;
          col = col + 8'd1;
          if (col == line_len && b64le_pkg::NUM_RES - n > rem - 1) begin
            push(b64le_pkg::NEWLINE_CODE, 8'd1, 1'b0);
            n++;
            col = '0;
          end
        end
        return;
      end

      // finish: flush, pad the line, newline
      finishes++;
      e = (line_len == 8'd0) ? 256 : int'(line_len);
      if (carry_cnt == 3'd0 && col == 8'd0) begin
        clear_state();
        return;
      end
      if (nl_held()) begin
        if (carry_cnt == 3'd0) begin
          push(b64le_pkg::NEWLINE_CODE, 8'd1, 1'b1);
          clear_state();
          return;
        end
        // only a one-character line leaves room for the owed newline
        if (e <= 1) push(b64le_pkg::NEWLINE_CODE, 8'd1, 1'b0);
        col = '0;
      end
      lc = int'(col);
      if (carry_cnt != 3'd0) begin
        tail = 6'({carry_bits, 8'h00} >> (int'(carry_cnt) + 2));
        push(sym_code(tail), 8'd1, 1'b0);
        lc++;
      end
      if (lc < e) push(b64le_pkg::PAD_CODE, 8'(e - lc), 1'b0);
      push(b64le_pkg::NEWLINE_CODE, 8'd1, 1'b1);
      clear_state();
    endfunction

    // Compares one output item with the oldest expected character
    function void check_char(logic [6:0] c, logic [7:0] r, logic l);
      b64le_pkg::res_t x;
      chars_seen++;
      if (c == b64le_pkg::NEWLINE_CODE) newlines++;
      if (c == b64le_pkg::PAD_CODE && r != 8'd1) pad_runs++;
      if (exp_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected output char_code %0d repeat_res %0d last %0b",
                 $time, c, r, l);
        return;
      end
      x = exp_chars.pop_front();
      if (x.char_code != c) begin
        errors++;
        $display("%0t: char_code expected %0d got %0d", $time, x.char_code, c);
      end
      if (x.repeat_res != r) begin
        errors++;
        $display("%0t: repeat_res expected %0d got %0d", $time, x.repeat_res, r);
      end
      if (x.last != l) begin
        errors++;
        $display("%0t: last expected %0b got %0b", $time, x.last, l);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       op = 1'b0;
  logic [7:0] data_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] char_code;
  logic [7:0] repeat_res;
  logic       last;

  char_scoreboard board = new();
  bit  quiet = 1'b0;
  int  stall_left = 0;
  int  roll;
  int  cycles = 0;
  int  cfg_writes = 0;

  base64_line_encoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_code  (char_code),
    .repeat_res (repeat_res),
    .last       (last)
  );

  always #CLK_HALF clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver backpressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        out_ready <= 1'b1;
      end else if (roll < 95) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        stall_left = $urandom_range(10, 40);
        out_ready <= 1'b0;
      end
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_char(char_code, repeat_res, last);
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Presents one item and waits until it is taken
  task automatic send_item(b64le_pkg::op_t o, logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    board.encode_item(o, b);
  endtask

  task automatic send_bytes(int len);
    for (int i = 0; i < len; i++) begin
      send_item(b64le_pkg::OP_DATA, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_finish();
    send_item(b64le_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // Hold the input until every expected character is out, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(logic [7:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_length(v);
    cfg_writes++;
  endtask

  initial begin
    logic [7:0] lengths [9];
    int sent;
    int len;
    int r;

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Byte extremes, empty finish, both flush widths at reset length
    send_item(b64le_pkg::OP_DATA, 8'h00);
    send_item(b64le_pkg::OP_DATA, 8'hFF);
    send_item(b64le_pkg::OP_DATA, 8'h00);
    send_item(b64le_pkg::OP_FINISH, 8'hFF);
    send_item(b64le_pkg::OP_FINISH, 8'h00);
    send_item(b64le_pkg::OP_DATA, 8'hFF);
    send_item(b64le_pkg::OP_FINISH, 8'h00);
    send_item(b64le_pkg::OP_DATA, 8'h80);
    send_item(b64le_pkg::OP_DATA, 8'h7F);
    send_item(b64le_pkg::OP_FINISH, 8'hFF);

    // One-character lines: newline carried over to the next item
    write_length(8'd1);
    send_item(b64le_pkg::OP_DATA, 8'hA5);
    send_item(b64le_pkg::OP_DATA, 8'h5A);
    send_item(b64le_pkg::OP_DATA, 8'hC3);
    send_item(b64le_pkg::OP_FINISH, 8'h00);
    send_item(b64le_pkg::OP_DATA, 8'h12);
    send_item(b64le_pkg::OP_FINISH, 8'h00);

    // Line length written down to the column: owed newline lost on finish
    write_length(8'd10);
    send_item(b64le_pkg::OP_DATA, 8'h01);
    send_item(b64le_pkg::OP_DATA, 8'h23);
    send_item(b64le_pkg::OP_DATA, 8'h45);
    send_item(b64le_pkg::OP_DATA, 8'h67);
    write_length(8'd5);
    send_item(b64le_pkg::OP_FINISH, 8'h00);

    // Line length written below the column: finish without padding
    write_length(8'd76);
    send_item(b64le_pkg::OP_DATA, 8'hDE);
    send_item(b64le_pkg::OP_DATA, 8'hAD);
    send_item(b64le_pkg::OP_DATA, 8'hBE);
    write_length(8'd2);
    send_item(b64le_pkg::OP_FINISH, 8'h00);

    // Random phases over several line lengths, zero meaning 256
    lengths = '{8'd255, 8'd0, 8'd1, 8'd2, 8'd3, 8'd76, 8'd0, 8'd6, 8'd4};
    lengths[7] = 8'($urandom_range(4, 20));
    lengths[8] = 8'($urandom_range(1, 255));
    foreach (lengths[p]) begin
      write_length(lengths[p]);
      quiet = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          // whole message
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
          send_bytes(len);
          send_finish();
          sent += len + 1;
        end else if (r < 85) begin
          // message left open into the next one
          len = $urandom_range(1, 5);
          send_bytes(len);
          sent += len;
        end else if (r < 95) begin
          send_finish();
          sent++;
        end else begin
          settle();
        end
      end
      quiet = 1'b0;
    end

    settle();
    repeat (20) @(posedge clk);

    $display("Sent %0d items (%0d finishes) under %0d line length writes;",
             board.items, board.finishes, cfg_writes);
    $display("checked %0d output items, %0d padding runs, %0d newlines.",
             board.chars_seen, board.pad_runs, board.newlines);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
